/* hw/rtl/srbc_pkg.sv */
// ----------------------------------------------------------------------------
// srbc_pkg
// Shared types and fixed field widths for the sorted region bounds checker.
// ----------------------------------------------------------------------------
package srbc_pkg;

	localparam int ACTION_W = 2;
	localparam int LEN_W    = 32;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 7;

	typedef enum logic [ACTION_W-1:0] {
		ACT_ADD    = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_CHECK  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_OVERLAP   = 3'd1,
		ST_FULL      = 3'd2,
		ST_MISMATCH  = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_OVERRUN   = 3'd5,
		ST_NO_REGION = 3'd6,
		ST_ZERO_LEN  = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_SHIFT,
		S_PUT,
		S_OUT
	} state_t;

endpackage

/* hw/rtl/srbc_req_if.sv */
// ----------------------------------------------------------------------------
// srbc_req_if
// Request channel: action, address and length with valid/ready handshake.
// ----------------------------------------------------------------------------
interface srbc_req_if
	import srbc_pkg::*;
#(
	parameter int ADDR_WIDTH = 48
);
	logic                  valid;
	logic                  ready;
	logic [ACTION_W-1:0]   action;
	logic [ADDR_WIDTH-1:0] address;
	logic [LEN_W-1:0]      length;

	modport source (output valid, action, address, length, input ready);
	modport sink   (input valid, action, address, length, output ready);
endinterface

/* hw/rtl/srbc_rsp_if.sv */
// ----------------------------------------------------------------------------
// srbc_rsp_if
// Result channel: status and entry count with valid/ready handshake.
// ----------------------------------------------------------------------------
interface srbc_rsp_if
	import srbc_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  entry_count;

	modport source (output valid, status, entry_count, input ready);
	modport sink   (input valid, status, entry_count, output ready);
endinterface

/* hw/rtl/sorted_region_bounds_checker.sv */
// ----------------------------------------------------------------------------
// sorted_region_bounds_checker
// Sorted table of memory regions with add, remove and access bounds check.
// ----------------------------------------------------------------------------
// An add runs a search walk, a shift walk and an insert write; a remove, a
// search and a shift walk; a check, a search walk. One request at a time; the
// walks run one entry per cycle through the single read port of the region
// memory. Zero-length, full and unused-action requests skip the walks. Reset
// clears the region count and control state only; memory contents stay
// undefined and never read at or above the count, so no clearing pass is run.
// ----------------------------------------------------------------------------
module sorted_region_bounds_checker
	import srbc_pkg::*;
#(
	parameter int ENTRIES    = 64,
	parameter int ADDR_WIDTH = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	srbc_req_if.sink    req,
	srbc_rsp_if.source  rsp
);

	localparam int IW   = $clog2(ENTRIES);
	localparam int CNTW = $clog2(ENTRIES + 1);
	localparam int DW   = ADDR_WIDTH + LEN_W;
	localparam int CMPW = (ADDR_WIDTH > LEN_W) ? ADDR_WIDTH : LEN_W;
	localparam int CXW  = (CNTW > COUNT_W) ? CNTW : COUNT_W;

	// Region memory: each word holds {start, length}, kept sorted by start.
	logic [DW-1:0] region_mem [ENTRIES];

	state_t                state_q, state_d;
	action_t               act_q, act_d;
	logic [ADDR_WIDTH-1:0] addr_q, addr_d;
	logic [LEN_W-1:0]      len_q, len_d;
	logic [CNTW-1:0]       cnt_q, cnt_d;
	status_t               status_q, status_d;
	logic [CNTW-1:0]       ptr_q, ptr_d;     // next entry to read
	logic [CNTW-1:0]       left_q, left_d;   // reads still to issue
	logic [CNTW-1:0]       pos_q, pos_d;     // insert slot for an add
	logic [ADDR_WIDTH-1:0] prev_q, prev_d;   // start of the last entry passed
	logic                  seen_q, seen_d;   // some entry lies above the slot

	logic                  rd_en;
	logic [IW-1:0]         rd_addr;
	logic [DW-1:0]         rd_data_q;
	logic                  rd_vld_s1;
	logic [IW-1:0]         rd_idx_s1;
	logic                  wr_en;
	logic [IW-1:0]         wr_addr;
	logic [DW-1:0]         wr_data;

	logic                  rsp_valid_q;
	status_t               rsp_status_q;
	logic [COUNT_W-1:0]    rsp_count_q;
	logic                  out_load;
	logic [CXW-1:0]        cnt_wide;

	logic                  hit;
	logic                  walk_down;
	logic [CNTW-1:0]       slot;

	// Entry compare datapath on the registered read data.
	logic [ADDR_WIDTH-1:0] ent_start;
	logic [LEN_W-1:0]      ent_len;
	logic [ADDR_WIDTH-1:0] addr_off;
	logic [CMPW-1:0]       dist_x, ent_len_x, req_len_x, gap_x;
	logic                  a_ge_s, ends_by, overrun, overlap;

	assign ent_start = rd_data_q[DW-1:LEN_W];
	assign ent_len   = rd_data_q[LEN_W-1:0];
	assign a_ge_s    = addr_q >= ent_start;
	assign addr_off  = addr_q - ent_start;
	assign dist_x    = CMPW'(addr_off);
	assign ent_len_x = CMPW'(ent_len);
	assign req_len_x = CMPW'(len_q);
	// Entry ends at or before the new start.
	assign ends_by   = a_ge_s && (dist_x >= ent_len_x);
	// Access runs past the entry's end; compared exactly, no wraparound.
	assign overrun   = (dist_x > ent_len_x) || (req_len_x > (ent_len_x - dist_x));
	// New region reaches the next start; touching counts as overlap.
	assign gap_x     = CMPW'(prev_q - addr_q);
	assign overlap   = (prev_q <= addr_q) || (gap_x <= req_len_x);

	// Add and check walk downward; remove walks upward.
	assign walk_down = (act_q != ACT_REMOVE);

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.entry_count = rsp_count_q;
	assign cnt_wide        = CXW'(cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		act_d    = act_q;
		addr_d   = addr_q;
		len_d    = len_q;
		cnt_d    = cnt_q;
		status_d = status_q;
		ptr_d    = ptr_q;
		left_d   = left_q;
		pos_d    = pos_q;
		prev_d   = prev_q;
		seen_d   = seen_q;
		rd_en    = 1'b0;
		rd_addr  = ptr_q[IW-1:0];
		wr_en    = 1'b0;
		wr_addr  = '0;
		wr_data  = rd_data_q;
		out_load = 1'b0;
		hit      = 1'b0;
		slot     = '0;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					// Latch the request and pick the path.
					act_d  = action_t'(req.action);
					addr_d = req.address;
					len_d  = req.length;
					seen_d = 1'b0;
					if (action_t'(req.action) == ACT_NONE) begin
						status_d = ST_OK;
						state_d  = S_OUT;
					end else if (req.length == '0) begin
						status_d = ST_ZERO_LEN;
						state_d  = S_OUT;
					end else if (action_t'(req.action) == ACT_ADD &&
						cnt_q == CNTW'(ENTRIES)) begin
						status_d = ST_FULL;
						state_d  = S_OUT;
					end else begin
						ptr_d   = (action_t'(req.action) == ACT_REMOVE) ? '0 :
							cnt_q - CNTW'(1);
						left_d  = cnt_q;
						state_d = S_WALK;
					end
				end
			end
			S_WALK: begin
				if (rd_vld_s1) begin
					case (act_q)
						ACT_CHECK: begin
							// Highest region starting at or below the address decides.
							if (a_ge_s) begin
								hit      = 1'b1;
								status_d = overrun ? ST_OVERRUN : ST_OK;
								state_d  = S_OUT;
							end
						end
						ACT_ADD: begin
							if (ends_by) begin
								hit  = 1'b1;
								slot = CNTW'(rd_idx_s1) + CNTW'(1);
							end else begin
								// Remember this start: it is the next region if the
								// slot lands just below it.
								prev_d = ent_start;
								seen_d = 1'b1;
							end
						end
						ACT_REMOVE: begin
							if (ent_start == addr_q) begin
								hit = 1'b1;
								if (ent_len != len_q) begin
									status_d = ST_MISMATCH;
									state_d  = S_OUT;
								end else begin
									// Close the gap: move later entries down by one.
									pos_d   = CNTW'(rd_idx_s1);
									ptr_d   = CNTW'(rd_idx_s1) + CNTW'(1);
									left_d  = cnt_q - CNTW'(1) - CNTW'(rd_idx_s1);
									state_d = S_SHIFT;
								end
							end
						end
						default: ;
					endcase
				end
				if (!hit && !rd_vld_s1 && left_q == '0) begin
					// Walk exhausted without a match.
					case (act_q)
						ACT_CHECK:  begin
							status_d = ST_NO_REGION;
							state_d  = S_OUT;
						end
						ACT_REMOVE: begin
							status_d = ST_NOT_FOUND;
							state_d  = S_OUT;
						end
						ACT_ADD:    begin
							hit  = 1'b1;
							slot = '0;
						end
						default: state_d = S_OUT;
					endcase
				end
				if (hit && act_q == ACT_ADD) begin
					// Slot found: reject on overlap with the region above it,
					// else open the slot by moving entries up.
					if (seen_q && overlap) begin
						status_d = ST_OVERLAP;
						state_d  = S_OUT;
					end else begin
						pos_d   = slot;
						ptr_d   = cnt_q - CNTW'(1);
						left_d  = cnt_q - slot;
						state_d = S_SHIFT;
					end
				end
				if (!hit && left_q != '0) begin
					rd_en  = 1'b1;
					ptr_d  = walk_down ? ptr_q - CNTW'(1) : ptr_q + CNTW'(1);
					left_d = left_q - CNTW'(1);
				end
			end
			S_SHIFT: begin
				// Write each read entry one slot over, up for add, down for remove.
				if (rd_vld_s1) begin
					wr_en   = 1'b1;
					wr_addr = walk_down ? rd_idx_s1 + IW'(1) : rd_idx_s1 - IW'(1);
					wr_data = rd_data_q;
				end
				if (left_q != '0) begin
					rd_en  = 1'b1;
					ptr_d  = walk_down ? ptr_q - CNTW'(1) : ptr_q + CNTW'(1);
					left_d = left_q - CNTW'(1);
				end else if (!rd_vld_s1) begin
					if (act_q == ACT_REMOVE) begin
						cnt_d    = cnt_q - CNTW'(1);
						status_d = ST_OK;
						state_d  = S_OUT;
					end else begin
						state_d = S_PUT;
					end
				end
			end
			S_PUT: begin
				// Drop the new region into the opened slot.
				wr_en    = 1'b1;
				wr_addr  = pos_q[IW-1:0];
				wr_data  = {addr_q, len_q};
				cnt_d    = cnt_q + CNTW'(1);
				status_d = ST_OK;
				state_d  = S_OUT;
			end
			S_OUT: begin
				// Hold until the result register is free.
				if (!rsp_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			left_q      <= '0;
			rd_vld_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			cnt_q     <= cnt_d;
			left_q    <= left_d;
			rd_vld_s1 <= rd_en;
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		act_q    <= act_d;
		addr_q   <= addr_d;
		len_q    <= len_d;
		status_q <= status_d;
		ptr_q    <= ptr_d;
		pos_q    <= pos_d;
		prev_q   <= prev_d;
		seen_q   <= seen_d;
		if (rd_en) begin
			rd_idx_s1 <= rd_addr;
		end
		if (out_load) begin
			rsp_status_q <= status_q;
			rsp_count_q  <= cnt_wide[COUNT_W-1:0];
		end
	end

	// Region memory, one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			region_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= region_mem[rd_addr];
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(ENTRIES))
		else $error("region count above table depth");

	a_cnt_change: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |-> ($past(state_q) == S_PUT || $past(state_q) == S_SHIFT))
		else $error("region count changed outside insert or remove");

	a_no_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK || state_q == S_IDLE) |-> !wr_en)
		else $error("memory written during search");

	a_read_source: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> ($past(state_q) == S_WALK || $past(state_q) == S_SHIFT))
		else $error("read data valid without a walk");

endmodule
